[hdl/multi_touch_threshold_scanner_core_assert.svh]
// Assertion macros for the touch threshold scanner core.
`ifndef MULTI_TOUCH_THRESHOLD_SCANNER_CORE_ASSERT_SVH
`define MULTI_TOUCH_THRESHOLD_SCANNER_CORE_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define MTTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define MTTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mtts_pkg.sv]
// Constants shared by the touch threshold scanner core.
`default_nettype none
package mtts_pkg;
  localparam int IDX_W = 3;
  localparam int CNT_W = 16;
  localparam int CLIP_W = 14;
  localparam int SENSOR_COUNT_DEF = 8;
  localparam int PROD_W = CLIP_W + 16;
  localparam int DIV5_SHIFT = 18;
  localparam int QUOT_W = PROD_W - DIV5_SHIFT;

  localparam logic [CLIP_W-1:0] COUNT_CLIP = 14'd10000;
  localparam logic [CLIP_W-1:0] THR_MARGIN = 14'd100;
  localparam logic [CLIP_W-1:0] THR_RESET = 14'd50;
  localparam logic [15:0] DIV5_MUL = 16'd52429;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CALIBRATE = 1'b1;
endpackage
`default_nettype wire

[hdl/multi_touch_threshold_scanner_core.sv]
// Top level of the touch threshold scanner: threshold memory, touch flags, result register.
//
// One request is accepted per clock while in_stall is low. The first stage reads the
// sensor's threshold from a synchronous memory into a register; the second compares,
// writes back and fills the result register. A calibrate write that meets a read of the
// same sensor in the next request is forwarded, and thresholds never written since reset
// read as 50. Input stall rises only when a result is waiting in the output register, a
// request waits behind it, and the output side stalls.
`default_nettype none
`include "multi_touch_threshold_scanner_core_assert.svh"
module multi_touch_threshold_scanner_core
  import mtts_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_req_type,
  input  wire logic [IDX_W-1:0]  in_sensor_index,
  input  wire logic [CNT_W-1:0]  in_discharge_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IDX_W-1:0]       out_event_sensor,
  output logic [CLIP_W-1:0]      out_clipped_count,
  output logic                   out_touched,
  output logic                   out_press_event,
  output logic                   out_release_event,
  output logic                   out_first_valid,
  output logic [IDX_W-1:0]       out_first_index
);
  localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int EW = (AW > IDX_W) ? AW : IDX_W;

  logic [CLIP_W-1:0] thr_mem [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] thr_vld_r, thr_vld_nxt;
  logic [SENSOR_COUNT-1:0] flags_r, flags_nxt;

  logic s1_v_r, s1_v_nxt;
  logic s1_cal_r, s1_inr_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [AW-1:0] s1_addr_r;
  logic [CLIP_W-1:0] s1_clip_r, s1_thr_new_r;
  logic [CLIP_W-1:0] rd_data_r, byp_data_r;
  logic rd_vld_r, byp_hit_r;

  logic out_v_r, out_v_nxt;
  logic [IDX_W-1:0] out_sensor_r, out_findex_r;
  logic [CLIP_W-1:0] out_clip_r;
  logic out_touched_r, out_press_r, out_release_r, out_fvalid_r;

  logic in_acc, s1_adv, wr_thr, wr_flag;
  logic [EW-1:0] idx_ext;
  logic [AW-1:0] in_addr;
  logic in_inr;
  logic [CLIP_W-1:0] in_clip, in_thr_new, thr_cur;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic now_touch, old_touch;
  logic touched_c, press_c, release_c, fvalid_c;
  logic [IDX_W-1:0] findex_c;

  assign s1_adv = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc = in_valid && !in_stall;

  assign idx_ext = EW'(in_sensor_index);
  assign in_addr = idx_ext[AW-1:0];
  assign in_inr = 32'(in_sensor_index) < SENSOR_COUNT;
  assign in_clip = (in_discharge_count > CNT_W'(COUNT_CLIP)) ? COUNT_CLIP
                                                               : in_discharge_count[CLIP_W-1:0];
  assign prod = PROD_W'(in_clip) * PROD_W'(DIV5_MUL);
  assign quot = prod[PROD_W-1:DIV5_SHIFT];
  assign in_thr_new = CLIP_W'(15'(in_clip) + 15'(quot) + 15'(THR_MARGIN));

  assign thr_cur = byp_hit_r ? byp_data_r : (rd_vld_r ? rd_data_r : THR_RESET);
  assign old_touch = flags_r[s1_addr_r];
  assign now_touch = s1_clip_r > thr_cur;
  assign wr_thr = s1_adv && s1_inr_r && (s1_cal_r == REQ_CALIBRATE);
  assign wr_flag = s1_adv && s1_inr_r && (s1_cal_r == REQ_MEASURE);

  always_comb begin
    flags_nxt = flags_r;
    thr_vld_nxt = thr_vld_r;
    touched_c = 1'b0;
    press_c = 1'b0;
    release_c = 1'b0;
    if (s1_inr_r) begin
      if (s1_cal_r == REQ_CALIBRATE) begin
        touched_c = old_touch;
      end else begin
        touched_c = now_touch;
        press_c = now_touch && !old_touch;
        release_c = !now_touch && old_touch;
      end
    end
    if (wr_flag) begin
      flags_nxt[s1_addr_r] = now_touch;
    end
    if (wr_thr) begin
      thr_vld_nxt[s1_addr_r] = 1'b1;
    end
  end

  always_comb begin
    fvalid_c = |flags_nxt;
    findex_c = '0;
    for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
      if (flags_nxt[i]) begin
        findex_c = IDX_W'(i);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_thr) begin
      thr_mem[s1_addr_r] <= s1_thr_new_r;
    end
    if (in_acc) begin
      rd_data_r <= thr_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
      flags_r <= '0;
      thr_vld_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      flags_r <= flags_nxt;
      thr_vld_r <= thr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cal_r <= in_req_type;
      s1_inr_r <= in_inr;
      s1_idx_r <= in_sensor_index;
      s1_addr_r <= in_addr;
      s1_clip_r <= in_clip;
      s1_thr_new_r <= in_thr_new;
      rd_vld_r <= thr_vld_nxt[in_addr];
      byp_hit_r <= wr_thr && (s1_addr_r == in_addr);
      byp_data_r <= s1_thr_new_r;
    end
    if (s1_adv) begin
      out_sensor_r <= s1_idx_r;
      out_clip_r <= s1_clip_r;
      out_touched_r <= touched_c;
      out_press_r <= press_c;
      out_release_r <= release_c;
      out_fvalid_r <= fvalid_c;
      out_findex_r <= findex_c;
    end
  end

  assign out_valid = out_v_r;
  assign out_event_sensor = out_sensor_r;
  assign out_clipped_count = out_clip_r;
  assign out_touched = out_touched_r;
  assign out_press_event = out_press_r;
  assign out_release_event = out_release_r;
  assign out_first_valid = out_fvalid_r;
  assign out_first_index = out_findex_r;

  `MTTS_ASSERT_SAME(a_no_dual_edge, out_v_r, !(out_press_r && out_release_r),
                    "press and release reported together")
  `MTTS_ASSERT_SAME(a_press_touched, out_v_r && out_press_r, out_touched_r,
                    "press reported on an untouched sensor")
  `MTTS_ASSERT_SAME(a_first_valid_flags, out_v_r, out_fvalid_r == (|flags_r),
                    "first_valid disagrees with the touch flags")
  `MTTS_ASSERT_NEXT(a_accept_fills_s1, in_acc, s1_v_r,
                    "accepted request lost before the compare stage")
endmodule
`default_nettype wire
